### hw/rtl/fcca_pkg.sv
`timescale 1ns / 1ps

package fcca_pkg;

    // Fixed field widths of the stream items.
    localparam int SIZE_W = 22;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;

    // Operation codes carried on the input tuser.
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Status codes carried on the output tuser.
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [ST_W-1:0] ST_BADHEAD = 2'd2;

    // Result kinds that the controller asks the datapath to build.
    localparam int RES_W = 3;
    localparam logic [RES_W-1:0] RES_NOP      = 3'd0;
    localparam logic [RES_W-1:0] RES_EMPTY    = 3'd1;
    localparam logic [RES_W-1:0] RES_NOFIT    = 3'd2;
    localparam logic [RES_W-1:0] RES_BADHEAD  = 3'd3;
    localparam logic [RES_W-1:0] RES_ALLOC_OK = 3'd4;
    localparam logic [RES_W-1:0] RES_OOB_READ = 3'd5;
    localparam logic [RES_W-1:0] RES_LOOK     = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;       // latch the accepted input beat
        logic             clr_wr;     // one step of the table clearing pass
        logic             cap;        // register free capacity in bytes
        logic             scan_start; // set up a first-fit scan
        logic             scan;       // one scan step
        logic             tail;       // write the end marker of a new chain
        logic             fetch;      // read the entry at the current cluster
        logic             walk;       // one step of a free walk
        logic             set_res;    // build a result of kind res_kind
        logic [RES_W-1:0] res_kind;
        logic             out_load;   // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic            clr_last;
        logic [OP_W-1:0] op;
        logic            size_zero;
        logic            too_big;
        logic            head_bad;
        logic            head_oob;
        logic            found;
        logic            last_clu;
        logic            walk_end;
        logic            walk_bad;
        logic            out_free;
    } t_dp_sts;

endpackage

### hw/rtl/fcca_ctrl.sv
`timescale 1ns / 1ps

module fcca_ctrl
    import fcca_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_TAIL   = 4'd5;
    localparam logic [3:0] S_FETCH  = 4'd6;
    localparam logic [3:0] S_WALK   = 4'd7;
    localparam logic [3:0] S_LOOK   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.cap = 1'b1;
                case (i_sts.op)
                    OP_ALLOC: begin
                        n_state = S_CMP;
                    end
                    OP_FREE: begin
                        if (i_sts.head_bad) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_kind = RES_BADHEAD;
                            n_state        = S_OUT;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                    OP_READ: begin
                        if (i_sts.head_oob) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_kind = RES_OOB_READ;
                            n_state        = S_OUT;
                        end else begin
                            n_state = S_FETCH;
                        end
                    end
                    default: begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_kind = RES_NOP;
                        n_state        = S_OUT;
                    end
                endcase
            end
            S_CMP: begin
                if (i_sts.size_zero) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_kind = RES_EMPTY;
                    n_state        = S_OUT;
                end else if (i_sts.too_big) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_kind = RES_NOFIT;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found && i_sts.last_clu) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                o_cmd.tail     = 1'b1;
                o_cmd.set_res  = 1'b1;
                o_cmd.res_kind = RES_ALLOC_OK;
                n_state        = S_OUT;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = (i_sts.op == OP_FREE) ? S_WALK : S_LOOK;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_end) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_kind = i_sts.walk_bad ? RES_BADHEAD : RES_EMPTY;
                    n_state        = S_OUT;
                end
            end
            S_LOOK: begin
                o_cmd.set_res  = 1'b1;
                o_cmd.res_kind = RES_LOOK;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/fcca_dp.sv
`timescale 1ns / 1ps

module fcca_dp
    import fcca_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int CLUSTER_BYTES = 512,
    localparam int CW     = $clog2(TABLE_ENTRIES),
    localparam int IN_DW  = ((SIZE_W + CW + 7) / 8) * 8,
    localparam int OUT_DW = ((CW + 2 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IN_DW-1:0]  i_s_tdata,
    input  logic [OP_W-1:0]   i_s_tuser,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic [OUT_DW-1:0] o_m_tdata,
    output logic [ST_W-1:0]   o_m_tuser,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts
);

    localparam int EW    = $clog2(TABLE_ENTRIES + 1);
    localparam int BW    = $clog2(CLUSTER_BYTES + 1);
    localparam int CAP_W = CW + BW;
    localparam int CMP_W = (SIZE_W > CAP_W) ? SIZE_W : CAP_W;

    localparam logic [EW-1:0]     END_V    = EW'(TABLE_ENTRIES);
    localparam logic [CW-1:0]     LAST_IDX = CW'(TABLE_ENTRIES - 1);
    localparam logic [SIZE_W-1:0] B_SZ     = SIZE_W'(CLUSTER_BYTES);
    localparam logic [BW-1:0]     B_MUL    = BW'(CLUSTER_BYTES);
    localparam logic [CW:0]       N_EXT    = (CW + 1)'(TABLE_ENTRIES);

    // Link table: 0 free, END_V end marker, otherwise the next cluster.
    logic [EW-1:0] r_mem [0:TABLE_ENTRIES-1];
    logic [EW-1:0] r_rdata;
    logic [CW-1:0] r_ridx;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [CW-1:0] rd_addr;

    logic [OP_W-1:0]   r_op, n_op;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_cur, n_cur;
    logic [CW-1:0]     r_prev, n_prev;
    logic [CW-1:0]     r_head, n_head;
    logic              r_rvld, n_rvld;
    logic              r_have_prev, n_have_prev;
    logic              r_first, n_first;
    logic [CW-1:0]     r_free_cnt, n_free_cnt;
    logic [CW:0]       r_steps, n_steps;
    logic [CAP_W-1:0]  r_cap;

    logic [ST_W-1:0] r_res_st, n_res_st;
    logic [CW-1:0]   r_res_cl, n_res_cl;
    logic            r_res_end, n_res_end;
    logic            r_res_free, n_res_free;

    logic            r_out_valid, n_out_valid;
    logic [ST_W-1:0] r_out_st;
    logic [CW-1:0]   r_out_cl;
    logic            r_out_end;
    logic            r_out_free;

    logic [CW-1:0] v_idx;
    logic          v_zero;
    logic          v_end;
    logic [CW:0]   steps_inc;
    logic          walk_limit;
    logic          found;
    logic          last_clu;
    logic          head_oob;

    // Decode of the entry read in the previous cycle.
    assign v_idx      = r_rdata[CW-1:0];
    assign v_zero     = (r_rdata == '0);
    assign v_end      = (r_rdata >= END_V);
    assign steps_inc  = r_steps + (CW + 1)'(1);
    assign walk_limit = (steps_inc == N_EXT);
    assign found      = r_rvld && v_zero;
    assign last_clu   = (r_rem <= B_SZ);
    assign head_oob   = ((CW + 1)'(r_cur) >= N_EXT);

    // Status toward the controller.
    always_comb begin
        o_sts.clr_last  = (r_idx == LAST_IDX);
        o_sts.op        = r_op;
        o_sts.size_zero = (r_rem == '0);
        o_sts.too_big   = (CMP_W'(r_rem) > CMP_W'(r_cap));
        o_sts.head_bad  = (r_cur == '0) || head_oob;
        o_sts.head_oob  = head_oob;
        o_sts.found     = found;
        o_sts.last_clu  = last_clu;
        o_sts.walk_end  = v_zero || v_end || walk_limit;
        o_sts.walk_bad  = r_first && v_zero;
        o_sts.out_free  = !r_out_valid || i_m_tready;
    end

    // Next-state logic of the datapath registers and the table port.
    always_comb begin
        n_op        = r_op;
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_head      = r_head;
        n_rvld      = i_cmd.scan;
        n_have_prev = r_have_prev;
        n_first     = r_first;
        n_free_cnt  = r_free_cnt;
        n_steps     = r_steps;
        n_res_st    = r_res_st;
        n_res_cl    = r_res_cl;
        n_res_end   = r_res_end;
        n_res_free  = r_res_free;
        n_out_valid = r_out_valid;
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = '0;
        rd_addr     = r_cur;

        // Accepted beat.
        if (i_cmd.load) begin
            n_op  = i_s_tuser;
            n_rem = i_s_tdata[SIZE_W-1:0];
            n_cur = i_s_tdata[SIZE_W +: CW];
        end

        // Clearing pass: entry 0 is reserved, the rest become free.
        if (i_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_idx;
            wr_data = (r_idx == '0) ? END_V : '0;
            n_idx   = (r_idx == LAST_IDX) ? '0 : r_idx + CW'(1);
        end

        if (i_cmd.scan_start) begin
            n_idx       = CW'(1);
            n_have_prev = 1'b0;
            n_head      = '0;
        end

        // First-fit scan: one read issued per cycle, the previous one examined.
        if (i_cmd.scan) begin
            rd_addr = r_idx;
            if (r_idx != LAST_IDX) begin
                n_idx = r_idx + CW'(1);
            end
            if (found) begin
                if (r_have_prev) begin
                    wr_en   = 1'b1;
                    wr_addr = r_prev;
                    wr_data = EW'(r_ridx);
                end else begin
                    n_head = r_ridx;
                end
                n_prev      = r_ridx;
                n_have_prev = 1'b1;
                n_free_cnt  = r_free_cnt - CW'(1);
                if (!last_clu) begin
                    n_rem = r_rem - B_SZ;
                end
            end
        end

        // Close the new chain.
        if (i_cmd.tail) begin
            wr_en   = 1'b1;
            wr_addr = r_prev;
            wr_data = END_V;
        end

        if (i_cmd.fetch) begin
            rd_addr = r_cur;
            n_first = 1'b1;
            n_steps = '0;
        end

        // Free walk: clear the current entry and follow its link.
        if (i_cmd.walk) begin
            rd_addr = v_idx;
            if (!v_zero) begin
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = '0;
                if (r_free_cnt != LAST_IDX) begin
                    n_free_cnt = r_free_cnt + CW'(1);
                end
                n_steps = steps_inc;
                n_first = 1'b0;
                if (!v_end) begin
                    n_cur = v_idx;
                end
            end
        end

        // Result build.
        if (i_cmd.set_res) begin
            n_res_st   = ST_OK;
            n_res_cl   = '0;
            n_res_end  = 1'b0;
            n_res_free = 1'b0;
            case (i_cmd.res_kind)
                RES_EMPTY: begin
                    n_res_end = 1'b1;
                end
                RES_NOFIT: begin
                    n_res_st  = ST_NOFIT;
                    n_res_end = 1'b1;
                end
                RES_BADHEAD: begin
                    n_res_st = ST_BADHEAD;
                end
                RES_ALLOC_OK: begin
                    n_res_cl = r_head;
                end
                RES_OOB_READ: begin
                    n_res_free = 1'b1;
                end
                RES_LOOK: begin
                    if (v_zero) begin
                        n_res_free = 1'b1;
                    end else if (v_end) begin
                        n_res_end = 1'b1;
                    end else begin
                        n_res_cl = v_idx;
                    end
                end
                default: begin
                    n_res_st = ST_OK;
                end
            endcase
        end

        // Output register: a beat stays until the receiver takes it.
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
        r_ridx  <= rd_addr;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_rvld      <= 1'b0;
            r_free_cnt  <= LAST_IDX;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_rvld      <= n_rvld;
            r_free_cnt  <= n_free_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_rem       <= n_rem;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_head      <= n_head;
        r_have_prev <= n_have_prev;
        r_first     <= n_first;
        r_steps     <= n_steps;
        r_res_st    <= n_res_st;
        r_res_cl    <= n_res_cl;
        r_res_end   <= n_res_end;
        r_res_free  <= n_res_free;
        if (i_cmd.cap) begin
            r_cap <= CAP_W'(r_free_cnt) * CAP_W'(B_MUL);
        end
        if (i_cmd.out_load) begin
            r_out_st   <= r_res_st;
            r_out_cl   <= r_res_cl;
            r_out_end  <= r_res_end;
            r_out_free <= r_res_free;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DW'({r_out_free, r_out_end, r_out_cl});
    assign o_m_tuser  = r_out_st;

`ifndef ASSERT_OFF
    // The scan never hands out the reserved cluster.
    a_scan_not_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && found) |-> (r_ridx != '0))
        else $error("scan picked the reserved cluster");

    // Each cluster taken by the scan lowers the free count by one.
    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && found) |=> (r_free_cnt == $past(r_free_cnt) - CW'(1)))
        else $error("free count not decremented on allocation");

    // A free walk never clears the reserved cluster.
    a_walk_not_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk && !v_zero) |-> (r_cur != '0))
        else $error("free walk reached the reserved cluster");

    // A result is never loaded over one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten");
`endif

endmodule

### hw/rtl/fat_cluster_chain_allocator_top.sv
`timescale 1ns / 1ps

// First-fit cluster chain allocator over a link table of TABLE_ENTRIES entries.
// Input channel (s_*): one beat is one command. tuser carries the operation
// (allocate, free chain, read link); tdata carries the byte size and the
// head cluster. Output channel (m_*): one beat per command, with the status
// on tuser and the cluster, end-of-chain and free flags on tdata.
// After reset the table is swept once, one entry per cycle, with tready low
// until the sweep is done; cluster 0 ends up reserved and all others free.
// Commands run one at a time; a new one can be accepted in the cycle after
// the previous result moves into the output register. An unknown op or a
// free of cluster 0 is answered from decode, a zero-size or oversized
// allocation from the capacity compare, and a read link from the head entry.
// An allocation scans the table through the single memory read port, one
// entry per cycle, up to the last cluster it takes. A free walks the chain
// one entry per cycle; if its head entry is already free, the status is bad head.
// The result waits in an output register while the receiver holds tready
// low; the next command is accepted meanwhile, and its result waits in the
// result registers until the output register is free.
module fat_cluster_chain_allocator_top
    import fcca_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int CLUSTER_BYTES = 512,
    localparam int CW     = $clog2(TABLE_ENTRIES),
    localparam int IN_DW  = ((SIZE_W + CW + 7) / 8) * 8,
    localparam int OUT_DW = ((CW + 2 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_DW-1:0]  i_s_tdata,   // size_bytes, head_cluster, zero fill
    input  logic [OP_W-1:0]   i_s_tuser,   // op
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_DW-1:0] o_m_tdata,   // cluster, chain_end, is_free, zero fill
    output logic [ST_W-1:0]   o_m_tuser    // status
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    fcca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Table, counters and result registers.
    fcca_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CLUSTER_BYTES (CLUSTER_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule
